>>> design/mexp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mexp_pkg;
    localparam int OPW  = 32;
    localparam int CNTW = $clog2(OPW);

    typedef logic [OPW-1:0] word_t;

    // control into one multiplier cell
    typedef struct packed {
        logic start;
        logic mod_zero;
    } cell_ctl_t;
endpackage
`default_nettype wire

>>> design/modular_exponentiation_core.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   ports                           dir
// s_        s_valid s_ready s_base s_exponent  in
// m_        m_valid m_ready m_power_mod        out
// cfg_      cfg_valid cfg_ready cfg_data       in (modulus)
//
// for one word, each exponent bit runs
// two shift-add multiplier cells in parallel for 32 steps, plus one base reduction.
// a zero exponent skips the multiplier cells. reset sets modulus to 2, no clearing pass.
// a finished word waits in the output register; a stalled m_ready holds the next result.
module modular_exponentiation_core (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             s_valid,
    output logic            s_ready,
    input  mexp_pkg::word_t s_base,
    input  mexp_pkg::word_t s_exponent,
    output logic            m_valid,
    input  wire             m_ready,
    output mexp_pkg::word_t m_power_mod,
    input  wire             cfg_valid,
    output logic            cfg_ready,
    input  mexp_pkg::word_t cfg_data
);
    typedef enum logic [2:0] {S_IDLE, S_RED, S_STEP, S_MUL, S_DONE} state_t;

    state_t              state_reg;
    mexp_pkg::word_t     mod_reg;
    mexp_pkg::word_t     x_reg, q_reg, r_reg, out_reg;
    logic                out_valid_reg;
    mexp_pkg::cell_ctl_t ctl_a, ctl_b;
    mexp_pkg::word_t     a_in_a, b_in_a, prod_a, prod_b;
    logic                done_a, done_b, mz;

    assign mz        = (mod_reg == '0);
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_power_mod = out_reg;

    // cell start controls and operands
    always_comb begin
        ctl_a.start    = 1'b0;
        ctl_a.mod_zero = mz;
        ctl_b.start    = 1'b0;
        ctl_b.mod_zero = mz;
        a_in_a         = r_reg;
        b_in_a         = q_reg;
        if (state_reg == S_IDLE && s_valid && s_exponent != '0) begin
            ctl_a.start = 1'b1;
            a_in_a      = mexp_pkg::word_t'(1);
            b_in_a      = s_base;
        end else if (state_reg == S_STEP && x_reg != '0) begin
            ctl_a.start = 1'b1;
            ctl_b.start = 1'b1;
        end
    end

    mexp_cell u_cell_a (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl_a), .a(a_in_a), .b(b_in_a),
        .modulus(mod_reg), .product(prod_a), .done(done_a)
    );

    mexp_cell u_cell_b (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl_b), .a(q_reg), .b(q_reg),
        .modulus(mod_reg), .product(prod_b), .done(done_b)
    );

    // sequencer and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            mod_reg       <= mexp_pkg::word_t'(2);
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                mod_reg <= cfg_data;
            end
            // the done state reloads the output register itself
            if (out_valid_reg && m_ready && state_reg != S_DONE) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        x_reg <= s_exponent;
                        if (s_exponent == '0) begin
                            r_reg     <= mexp_pkg::word_t'(1);
                            state_reg <= S_DONE;
                        end else begin
                            state_reg <= S_RED;
                        end
                    end
                end
                S_RED: begin
                    if (done_a) begin
                        q_reg     <= prod_a;
                        r_reg     <= (mod_reg == mexp_pkg::word_t'(1)) ? '0
                                     : mexp_pkg::word_t'(1);
                        state_reg <= S_STEP;
                    end
                end
                S_STEP: begin
                    state_reg <= (x_reg == '0) ? S_DONE : S_MUL;
                end
                S_MUL: begin
                    if (done_b) begin
                        if (x_reg[0]) begin
                            r_reg <= prod_a;
                        end
                        q_reg     <= prod_b;
                        x_reg     <= x_reg >> 1;
                        state_reg <= S_STEP;
                    end
                end
                S_DONE: begin
                    if (!out_valid_reg || m_ready) begin
                        out_reg       <= r_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> design/mexp_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module mexp_cell (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  mexp_pkg::cell_ctl_t ctl,
    input  mexp_pkg::word_t     a,
    input  mexp_pkg::word_t     b,
    input  mexp_pkg::word_t     modulus,
    output mexp_pkg::word_t     product,
    output logic                done
);
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [mexp_pkg::CNTW-1:0] cnt_reg, cnt_next;
    mexp_pkg::word_t          acc_reg, acc_next;
    mexp_pkg::word_t          a_reg, a_next;
    mexp_pkg::word_t          b_reg, b_next;
    mexp_pkg::word_t          m_reg, m_next;
    logic                     mz_reg, mz_next;
    logic [mexp_pkg::OPW:0]   dbl_sum, add_sum;
    mexp_pkg::word_t          dbl_val, add_val;

    // one shift-add step: acc = 2*acc (+ a) mod m
    always_comb begin
        dbl_sum = {acc_reg, 1'b0};
        if (!mz_reg && dbl_sum >= {1'b0, m_reg}) begin
            dbl_sum = dbl_sum - {1'b0, m_reg};
        end
        dbl_val = dbl_sum[mexp_pkg::OPW-1:0];
        add_sum = {1'b0, dbl_val} + {1'b0, a_reg};
        if (!mz_reg && add_sum >= {1'b0, m_reg}) begin
            add_sum = add_sum - {1'b0, m_reg};
        end
        add_val = b_reg[mexp_pkg::OPW-1] ? add_sum[mexp_pkg::OPW-1:0] : dbl_val;
    end

    // sequencing of the bit steps
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        mz_next   = mz_reg;
        if (ctl.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            a_next    = a;
            b_next    = b;
            m_next    = modulus;
            mz_next   = ctl.mod_zero;
        end else if (busy_reg) begin
            acc_next = add_val;
            b_next   = {b_reg[mexp_pkg::OPW-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == mexp_pkg::CNTW'(mexp_pkg::OPW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
        mz_reg  <= mz_next;
    end

    assign product = acc_reg;
    assign done    = done_reg;
endmodule
`default_nettype wire

>>> tb/tb_modular_exponentiation_core.sv
`timescale 1ns / 1ps
module tb_modular_exponentiation_core;
    typedef struct {
        mexp_pkg::word_t base;
        mexp_pkg::word_t exponent;
    } exp_req_t;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    mexp_pkg::word_t s_base = '0;
    mexp_pkg::word_t s_exponent = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    mexp_pkg::word_t m_power_mod;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    mexp_pkg::word_t cfg_data = '0;

    exp_req_t        pending_words[$];
    mexp_pkg::word_t expected_powers[$];
    mexp_pkg::word_t cur_modulus;
    int              error_count = 0;
    int              cycle_count = 0;
    int              idle_pct = 10;
    int              hold_cycles = 0;
    bit              in_taken = 1'b0;

    modular_exponentiation_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_base(s_base), .s_exponent(s_exponent),
        .m_valid(m_valid), .m_ready(m_ready), .m_power_mod(m_power_mod),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #6 aclk = ~aclk;

    // modular product at full width; zero modulus truncates
    function automatic mexp_pkg::word_t mul_reduce(mexp_pkg::word_t a, mexp_pkg::word_t b,
                                                   mexp_pkg::word_t m);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, b};
        if (m == '0) return p[31:0];
        return mexp_pkg::word_t'(p % {32'd0, m});
    endfunction

    function automatic mexp_pkg::word_t predict_power(mexp_pkg::word_t base,
                                                      mexp_pkg::word_t exponent,
                                                      mexp_pkg::word_t m);
        mexp_pkg::word_t acc, sq, e;
        if (exponent == '0) return mexp_pkg::word_t'(1);
        acc = (m == '0) ? mexp_pkg::word_t'(1) : mexp_pkg::word_t'(1 % m);
        sq = (m == '0) ? base : base % m;
        e = exponent;
        while (e != '0) begin
            if (e[0]) acc = mul_reduce(acc, sq, m);
            e = e >> 1;
            sq = mul_reduce(sq, sq, m);
        end
        return acc;
    endfunction

    task automatic report_mismatch(string what, mexp_pkg::word_t got, mexp_pkg::word_t want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // driver: offers pending words at falling edges
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_taken)) begin
            in_taken <= 1'b0;
            if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
                s_valid <= 1'b1;
                s_base <= pending_words[0].base;
                s_exponent <= pending_words[0].exponent;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // accepted words leave the queue and get a prediction
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            in_taken <= 1'b1;
            void'(pending_words.pop_front());
            expected_powers.push_back(predict_power(s_base, s_exponent, cur_modulus));
        end
    end

    // receiver ready, random, with one long hold-off set by the test
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && ($urandom_range(99) >= idle_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_powers.size() == 0) begin
                report_mismatch("unexpected word", m_power_mod, '0);
            end else begin
                if (m_power_mod !== expected_powers[0])
                    report_mismatch("power_mod", m_power_mod, expected_powers[0]);
                void'(expected_powers.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2500000) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic push_word(mexp_pkg::word_t b, mexp_pkg::word_t e);
        exp_req_t r;
        r.base = b;
        r.exponent = e;
        pending_words.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || s_valid || expected_powers.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_modulus(mexp_pkg::word_t m);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cur_modulus = m;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic mexp_pkg::word_t rand_word();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return mexp_pkg::word_t'($urandom_range(15));
            default: return $urandom();
        endcase
    endfunction

    // mostly short exponents, a few full width
    function automatic mexp_pkg::word_t rand_exponent();
        case ($urandom_range(9))
            0: return '0;
            1: return $urandom();
            2: return '1;
            default: return mexp_pkg::word_t'($urandom_range(255));
        endcase
    endfunction

    initial begin
        mexp_pkg::word_t moduli[6];
        cur_modulus = mexp_pkg::word_t'(2);
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset modulus, then extremes and special cases
        push_word(32'd3, 32'd0);
        push_word(32'd5, 32'd3);
        wait_drained();
        write_modulus(32'd1);
        push_word(32'd7, 32'd0);
        push_word(32'd7, 32'd5);
        push_word('1, '1);
        wait_drained();
        write_modulus('0);
        push_word(32'd3, 32'd40);
        push_word('1, 32'd2);
        push_word(32'hdead_beef, '1);
        push_word(32'd0, 32'd0);
        push_word(32'd0, 32'd9);
        wait_drained();
        write_modulus('1);
        push_word('1, 32'd3);
        push_word(32'hffff_fffe, 32'hffff_fffe);
        push_word(32'h8000_0000, 32'd1);
        push_word(32'd2, 32'hffff_fffe);
        wait_drained();
        write_modulus(32'd97);
        push_word(32'd1000, 32'd96);
        push_word('1, 32'h5555_5555);
        push_word(32'haaaa_aaaa, 32'haaaa_aaaa);
        wait_drained();

        // long receiver stall while the sender keeps offering
        hold_cycles = 3000;
        for (int i = 0; i < 6; i++) push_word($urandom(), mexp_pkg::word_t'($urandom_range(63)));
        wait_drained();

        // random phases over several moduli, one with no idling
        moduli = '{32'hffff_fffb, 32'd1, 32'd0, 32'd65537, 32'h8000_0000, 32'd13};
        for (int ph = 0; ph < 6; ph++) begin
            write_modulus(ph == 5 ? $urandom() | 32'h1 : moduli[ph]);
            idle_pct = (ph == 3) ? 0 : 10;
            for (int i = 0; i < 45; i++) push_word(rand_word(), rand_exponent());
            wait_drained();
        end

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
